[hdl/gps_pkg.sv]
`timescale 1ns / 1ps
// Package for the gait phase scheduler: widths, register codes, configuration
// and inter-stage types, and field helpers. Used by every module; no dependencies.
package gps_pkg;

   localparam int LEG_COUNT           = 4;
   localparam int LANE_COUNT          = 2 * LEG_COUNT;
   localparam int DEF_MAX_HORIZON     = 16;
   localparam int DEF_ITERATION_WIDTH = 32;

   localparam int HORIZON_WIDTH   = 5;
   localparam int TICKS_WIDTH     = 11;
   localparam int OFFSETS_WIDTH   = 16;
   localparam int LENGTHS_WIDTH   = 20;
   localparam int OFF_WIDTH       = 4;
   localparam int LEN_WIDTH       = 5;
   localparam int SEG_WIDTH       = 4;
   localparam int FRAC_WIDTH      = 16;
   localparam int PHASE_WIDTH     = 16;
   localparam int PHASE_QUOT_WIDTH = 15;
   localparam int CONTACT_WIDTH   = 64;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 20;
   localparam int STEPS_PER_STAGE = 4;

   localparam logic [PHASE_WIDTH-1:0]   PHASE_ONE       = 16'h8000;
   localparam logic [HORIZON_WIDTH-1:0] RESET_HORIZON   = 5'd10;
   localparam logic [TICKS_WIDTH-1:0]   RESET_TICKS     = 11'd30;
   localparam logic [OFFSETS_WIDTH-1:0] RESET_OFFSETS   = 16'd1360;
   localparam logic [LENGTHS_WIDTH-1:0] RESET_LENGTHS   = 20'd169125;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HORIZON = 2'd0,
      CSR_TICKS   = 2'd1,
      CSR_OFFSETS = 2'd2,
      CSR_LENGTHS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [HORIZON_WIDTH-1:0] horizon;
      logic [TICKS_WIDTH-1:0]   ticks;
      logic [OFFSETS_WIDTH-1:0] offsets;
      logic [LENGTHS_WIDTH-1:0] lengths;
   } cfg_type;

   typedef struct packed {
      logic [SEG_WIDTH-1:0]  seg;
      logic [FRAC_WIDTH-1:0] frac;
   } seg_frac_type;

   typedef struct packed {
      logic [LEG_COUNT-1:0][PHASE_WIDTH-1:0] stance;
      logic [LEG_COUNT-1:0][PHASE_WIDTH-1:0] swing;
      logic [SEG_WIDTH-1:0]                  seg;
      logic [FRAC_WIDTH-1:0]                 frac;
   } phase_result_type;

   // Stance start offset of one leg.
   function automatic logic [OFF_WIDTH-1:0] leg_offset(input cfg_type cfg, input int leg);
      return cfg.offsets[leg*OFF_WIDTH +: OFF_WIDTH];
   endfunction

   // Stance length of one leg, in segments.
   function automatic logic [LEN_WIDTH-1:0] leg_length(input cfg_type cfg, input int leg);
      return cfg.lengths[leg*LEN_WIDTH +: LEN_WIDTH];
   endfunction

endpackage

[hdl/gps_quot_pipe.sv]
`timescale 1ns / 1ps
// Pipelined long division of the iteration count by the ticks per segment.
// Gives the segment index and the fraction. Depends on gps_pkg.
module gps_quot_pipe
   import gps_pkg::*;
#(
   parameter int ITERATION_WIDTH = DEF_ITERATION_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [ITERATION_WIDTH-1:0] in_iteration,
   output logic                       out_valid,
   input  logic                       out_ready,
   output seg_frac_type               out_data
);

   localparam int TOTAL_STEPS = ITERATION_WIDTH + FRAC_WIDTH;
   localparam int STAGES = (TOTAL_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   typedef struct packed {
      logic [ITERATION_WIDTH-1:0] iter;
      logic [TICKS_WIDTH-1:0]     rem;
      logic [SEG_WIDTH-1:0]       segmod;
      logic [FRAC_WIDTH-1:0]      frac;
   } quot_stage_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   ready;
   quot_stage_type    stage_ff   [STAGES];
   quot_stage_type    stage_in   [STAGES];
   quot_stage_type    stage_prev [STAGES];

   // A stage takes a new item when it is empty or its successor moves on.
   always_comb begin
      ready[STAGES] = out_ready;
      for (int s = STAGES - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   // Four restoring division steps per stage. The count is shifted out from the
   // top, so zeros follow once it is used up and the fraction bits emerge.
   always_comb begin
      quot_stage_type             cur;
      logic [TICKS_WIDTH:0]       trial;
      logic [HORIZON_WIDTH-1:0]   seg2;
      logic                       take;
      int                         pos;
      stage_prev[0] = '{iter: in_iteration, rem: '0, segmod: '0, frac: '0};
      for (int s = 1; s < STAGES; s++) begin
         stage_prev[s] = stage_ff[s-1];
      end
      for (int s = 0; s < STAGES; s++) begin
         cur = stage_prev[s];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            pos   = s * STEPS_PER_STAGE + j;
            trial = '0;
            seg2  = '0;
            take  = 1'b0;
            if (pos < TOTAL_STEPS) begin
               trial    = {cur.rem, cur.iter[ITERATION_WIDTH-1]};
               cur.iter = cur.iter << 1;
               take     = (trial >= {1'b0, cfg.ticks});
               if (take) begin
                  trial = trial - {1'b0, cfg.ticks};
               end
               cur.rem = trial[TICKS_WIDTH-1:0];
               if (pos < ITERATION_WIDTH) begin
                  // Keep only the quotient modulo the horizon.
                  seg2 = {cur.segmod, take};
                  if (seg2 >= cfg.horizon) begin
                     seg2 = seg2 - cfg.horizon;
                  end
                  cur.segmod = seg2[SEG_WIDTH-1:0];
               end else begin
                  cur.frac = {cur.frac[FRAC_WIDTH-2:0], take};
               end
            end
         end
         stage_in[s] = cur;
      end
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (ready[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign in_ready      = ready[0];
   assign out_valid     = valid_ff[STAGES-1];
   assign out_data.seg  = stage_ff[STAGES-1].segmod;
   assign out_data.frac = stage_ff[STAGES-1].frac;

endmodule

[hdl/gps_phase_pipe.sv]
`timescale 1ns / 1ps
// Per-leg phase pipeline: a set-up stage, then eight narrow dividers that
// give the stance and swing phases. Depends on gps_pkg.
module gps_phase_pipe
   import gps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  seg_frac_type     in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output phase_result_type out_data
);

   localparam int DIV_STAGES = (PHASE_QUOT_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int STAGES = 1 + DIV_STAGES;

   // Lanes 0 to 3 are stance phases, lanes 4 to 7 swing phases.
   typedef struct packed {
      logic [SEG_WIDTH-1:0]                        seg;
      logic [FRAC_WIDTH-1:0]                       frac;
      logic [FRAC_WIDTH-1:0]                       feed;
      logic [LANE_COUNT-1:0][LEN_WIDTH-1:0]        rem;
      logic [LANE_COUNT-1:0][LEN_WIDTH-1:0]        den;
      logic [LANE_COUNT-1:0][PHASE_QUOT_WIDTH-1:0] quot;
      logic [LANE_COUNT-1:0]                       active;
      logic [LEG_COUNT-1:0]                        one;
   } phase_stage_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   ready;
   phase_stage_type   setup_in;
   phase_stage_type   stage_ff [STAGES];
   phase_stage_type   stage_in [STAGES];

   always_comb begin
      ready[STAGES] = out_ready;
      for (int s = STAGES - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   // Set-up: position of each leg in the cycle and the run it is in.
   always_comb begin
      logic [LEN_WIDTH-1:0] off;
      logic [LEN_WIDTH-1:0] len;
      logic [LEN_WIDTH-1:0] diff;
      logic [LEN_WIDTH-1:0] rel;
      logic [LEN_WIDTH-1:0] sw_len;
      setup_in      = '0;
      setup_in.seg  = in_data.seg;
      setup_in.frac = in_data.frac;
      setup_in.feed = in_data.frac;
      for (int leg = 0; leg < LEG_COUNT; leg++) begin
         off  = {1'b0, leg_offset(cfg, leg)};
         len  = leg_length(cfg, leg);
         diff = {1'b0, in_data.seg} - off;
         if (diff[LEN_WIDTH-1]) begin
            diff = diff + cfg.horizon;
         end
         rel    = {1'b0, diff[SEG_WIDTH-1:0]};
         sw_len = cfg.horizon - len;
         setup_in.one[leg]              = (len == '0);
         setup_in.active[leg]           = (len != '0) && (rel < len);
         setup_in.rem[leg]              = rel;
         setup_in.den[leg]              = len;
         setup_in.active[leg+LEG_COUNT] = (sw_len != '0) && (rel >= len);
         setup_in.rem[leg+LEG_COUNT]    = rel - len;
         setup_in.den[leg+LEG_COUNT]    = sw_len;
      end
   end

   // Divider stages: four quotient bits per stage, the fraction fed in bit by bit.
   always_comb begin
      phase_stage_type    cur;
      logic [LEN_WIDTH:0] trial;
      logic               fbit;
      logic               take;
      int                 pos;
      stage_in[0] = setup_in;
      for (int s = 1; s < STAGES; s++) begin
         cur = stage_ff[s-1];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            pos = (s - 1) * STEPS_PER_STAGE + j;
            if (pos < PHASE_QUOT_WIDTH) begin
               fbit     = cur.feed[FRAC_WIDTH-1];
               cur.feed = cur.feed << 1;
               for (int u = 0; u < LANE_COUNT; u++) begin
                  trial = {cur.rem[u], fbit};
                  take  = (trial >= {1'b0, cur.den[u]});
                  if (take) begin
                     trial = trial - {1'b0, cur.den[u]};
                  end
                  cur.rem[u]  = trial[LEN_WIDTH-1:0];
                  cur.quot[u] = {cur.quot[u][PHASE_QUOT_WIDTH-2:0], take};
               end
            end
         end
         stage_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (ready[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   // Select each phase from its quotient, full scale or zero.
   always_comb begin
      out_data.seg  = stage_ff[STAGES-1].seg;
      out_data.frac = stage_ff[STAGES-1].frac;
      for (int leg = 0; leg < LEG_COUNT; leg++) begin
         if (stage_ff[STAGES-1].one[leg]) begin
            out_data.stance[leg] = PHASE_ONE;
         end else if (stage_ff[STAGES-1].active[leg]) begin
            out_data.stance[leg] = {1'b0, stage_ff[STAGES-1].quot[leg]};
         end else begin
            out_data.stance[leg] = '0;
         end
         if (stage_ff[STAGES-1].active[leg+LEG_COUNT]) begin
            out_data.swing[leg] = {1'b0, stage_ff[STAGES-1].quot[leg+LEG_COUNT]};
         end else begin
            out_data.swing[leg] = '0;
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[STAGES-1];

endmodule

[hdl/gait_phase_scheduler.sv]
`timescale 1ns / 1ps
// Gait phase scheduler top level: configuration registers, contact map and
// output register. Depends on gps_pkg, gps_quot_pipe and gps_phase_pipe.
//
// Usage: each item on the req_ channel carries a control iteration count and
// gives exactly one item on the rsp_ channel: segment index, fraction, stance
// and swing phase of each leg, the contact map and a configuration error flag.
// An item is taken at a clock edge where valid is high and stall is low.
// An item passes (ITERATION_WIDTH + 16) / 4 division stages, rounded up, then
// the phase set-up and divider stages and the output register. One item is
// accepted every cycle while req_stall is low; each divider pipeline retires
// four quotient bits per stage. When rsp_stall is held, stages fill up behind
// the output register and req_stall rises only once no stage is free; nothing
// is lost or repeated. The csr_ port writes one register per cycle; write only
// while no item is in flight. Synchronous reset empties the pipeline and loads
// the register defaults (horizon 10, 30 ticks per segment). An invalid
// configuration gives results with rsp_config_error set and all other fields zero.
module gait_phase_scheduler
   import gps_pkg::*;
#(
   parameter int MAX_HORIZON     = DEF_MAX_HORIZON,
   parameter int ITERATION_WIDTH = DEF_ITERATION_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ITERATION_WIDTH-1:0] req_control_iteration,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [SEG_WIDTH-1:0]       rsp_segment_index,
   output logic [FRAC_WIDTH-1:0]      rsp_segment_fraction,
   output logic [PHASE_WIDTH-1:0]     rsp_stance_phase_leg0,
   output logic [PHASE_WIDTH-1:0]     rsp_stance_phase_leg1,
   output logic [PHASE_WIDTH-1:0]     rsp_stance_phase_leg2,
   output logic [PHASE_WIDTH-1:0]     rsp_stance_phase_leg3,
   output logic [PHASE_WIDTH-1:0]     rsp_swing_phase_leg0,
   output logic [PHASE_WIDTH-1:0]     rsp_swing_phase_leg1,
   output logic [PHASE_WIDTH-1:0]     rsp_swing_phase_leg2,
   output logic [PHASE_WIDTH-1:0]     rsp_swing_phase_leg3,
   output logic [CONTACT_WIDTH-1:0]   rsp_contact_bits,
   output logic                       rsp_config_error
);

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic             config_bad;
   logic             req_ready;
   logic             mid_valid;
   logic             mid_ready;
   seg_frac_type     mid_data;
   logic             ph_valid;
   logic             ph_ready;
   phase_result_type ph_data;
   logic [CONTACT_WIDTH-1:0] contacts;

   logic                                   rsp_valid_ff;
   logic                                   rsp_error_ff;
   logic [SEG_WIDTH-1:0]                   rsp_seg_ff;
   logic [FRAC_WIDTH-1:0]                  rsp_frac_ff;
   logic [LEG_COUNT-1:0][PHASE_WIDTH-1:0]  rsp_stance_ff;
   logic [LEG_COUNT-1:0][PHASE_WIDTH-1:0]  rsp_swing_ff;
   logic [CONTACT_WIDTH-1:0]               rsp_contact_ff;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_HORIZON: cfg_in.horizon = csr_write_data[HORIZON_WIDTH-1:0];
            CSR_TICKS:   cfg_in.ticks   = csr_write_data[TICKS_WIDTH-1:0];
            CSR_OFFSETS: cfg_in.offsets = csr_write_data[OFFSETS_WIDTH-1:0];
            CSR_LENGTHS: cfg_in.lengths = csr_write_data[LENGTHS_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{horizon: RESET_HORIZON, ticks: RESET_TICKS,
                     offsets: RESET_OFFSETS, lengths: RESET_LENGTHS};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Configuration check: horizon, ticks and every leg's offset and length.
   always_comb begin
      config_bad = (cfg_ff.horizon == '0) ||
                   (cfg_ff.horizon > HORIZON_WIDTH'(MAX_HORIZON)) ||
                   (cfg_ff.ticks == '0);
      for (int leg = 0; leg < LEG_COUNT; leg++) begin
         if ({1'b0, leg_offset(cfg_ff, leg)} >= cfg_ff.horizon ||
             leg_length(cfg_ff, leg) > cfg_ff.horizon) begin
            config_bad = 1'b1;
         end
      end
   end

   gps_quot_pipe #(
      .ITERATION_WIDTH (ITERATION_WIDTH)
   ) u_quot (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_iteration (req_control_iteration),
      .out_valid    (mid_valid),
      .out_ready    (mid_ready),
      .out_data     (mid_data)
   );

   gps_phase_pipe u_phase (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (ph_valid),
      .out_ready (ph_ready),
      .out_data  (ph_data)
   );

   // Contact map over the horizon, starting at the current segment.
   always_comb begin
      logic [HORIZON_WIDTH-1:0] cur_seg;
      logic [HORIZON_WIDTH-1:0] rel;
      contacts = '0;
      for (int step = 0; step < MAX_HORIZON; step++) begin
         for (int leg = 0; leg < LEG_COUNT; leg++) begin
            cur_seg = {1'b0, ph_data.seg} + HORIZON_WIDTH'(step);
            if (cur_seg >= cfg_ff.horizon) begin
               cur_seg = cur_seg - cfg_ff.horizon;
            end
            rel = cur_seg - {1'b0, leg_offset(cfg_ff, leg)};
            if (rel[HORIZON_WIDTH-1]) begin
               rel = rel + cfg_ff.horizon;
            end
            if (HORIZON_WIDTH'(step) < cfg_ff.horizon) begin
               contacts[step*LEG_COUNT+leg] = (rel < leg_length(cfg_ff, leg));
            end
         end
      end
   end

   // Output register; it takes a new item whenever it is empty or being read.
   assign ph_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ph_ready) begin
         rsp_valid_ff <= ph_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ph_ready) begin
         rsp_error_ff <= config_bad;
         if (config_bad) begin
            rsp_seg_ff     <= '0;
            rsp_frac_ff    <= '0;
            rsp_stance_ff  <= '0;
            rsp_swing_ff   <= '0;
            rsp_contact_ff <= '0;
         end else begin
            rsp_seg_ff     <= ph_data.seg;
            rsp_frac_ff    <= ph_data.frac;
            rsp_stance_ff  <= ph_data.stance;
            rsp_swing_ff   <= ph_data.swing;
            rsp_contact_ff <= contacts;
         end
      end
   end

   assign req_stall             = !req_ready;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_config_error      = rsp_error_ff;
   assign rsp_segment_index     = rsp_seg_ff;
   assign rsp_segment_fraction  = rsp_frac_ff;
   assign rsp_stance_phase_leg0 = rsp_stance_ff[0];
   assign rsp_stance_phase_leg1 = rsp_stance_ff[1];
   assign rsp_stance_phase_leg2 = rsp_stance_ff[2];
   assign rsp_stance_phase_leg3 = rsp_stance_ff[3];
   assign rsp_swing_phase_leg0  = rsp_swing_ff[0];
   assign rsp_swing_phase_leg1  = rsp_swing_ff[1];
   assign rsp_swing_phase_leg2  = rsp_swing_ff[2];
   assign rsp_swing_phase_leg3  = rsp_swing_ff[3];
   assign rsp_contact_bits      = rsp_contact_ff;

`ifndef NO_ASSERTIONS
   // An error result carries nothing else.
   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_config_error |->
         rsp_segment_index == '0 && rsp_segment_fraction == '0 &&
         rsp_stance_phase_leg0 == '0 && rsp_swing_phase_leg0 == '0 &&
         rsp_contact_bits == '0)
      else $error("error result with non-zero fields");

   // A good result lies inside the horizon.
   a_seg_in_horizon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_config_error |->
         {1'b0, rsp_segment_index} < cfg_ff.horizon)
      else $error("segment index outside horizon");

   // Phases never exceed full scale.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stance_phase_leg0 <= PHASE_ONE &&
                    rsp_swing_phase_leg3 <= PHASE_ONE)
      else $error("phase above full scale");

   // Leg 0 not in contact now means no partial stance phase.
   a_contact_stance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_config_error && !rsp_contact_bits[0] |->
         rsp_stance_phase_leg0 == '0 || rsp_stance_phase_leg0 == PHASE_ONE)
      else $error("stance phase without contact");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for gait_phase_scheduler: drives iteration counts,
// predicts segment, phases and contact map, and checks every result item.
// Depends on gps_pkg and the gait_phase_scheduler RTL.

import gps_pkg::*;

typedef struct {
   logic [SEG_WIDTH-1:0]     seg;
   logic [FRAC_WIDTH-1:0]    frac;
   logic [PHASE_WIDTH-1:0]   stance [LEG_COUNT];
   logic [PHASE_WIDTH-1:0]   swing [LEG_COUNT];
   logic [CONTACT_WIDTH-1:0] contacts;
   logic                     cfg_err;
} gait_result_type;

// Holds the register copy, predicts each result and compares arrivals.
class gait_scoreboard;
   logic [HORIZON_WIDTH-1:0] horizon = RESET_HORIZON;
   logic [TICKS_WIDTH-1:0]   ticks = RESET_TICKS;
   logic [OFFSETS_WIDTH-1:0] offsets = RESET_OFFSETS;
   logic [LENGTHS_WIDTH-1:0] lengths = RESET_LENGTHS;
   gait_result_type pending_results[$];
   int mismatches = 0;
   int checked = 0;
   int error_results = 0;

   function void write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_HORIZON: horizon = data[HORIZON_WIDTH-1:0];
         CSR_TICKS:   ticks = data[TICKS_WIDTH-1:0];
         CSR_OFFSETS: offsets = data[OFFSETS_WIDTH-1:0];
         CSR_LENGTHS: lengths = data[LENGTHS_WIDTH-1:0];
      endcase
   endfunction

   function longint unsigned clip_phase(longint unsigned e, longint unsigned f,
                                        longint unsigned d);
      longint unsigned p;
      p = (e * 65536 + f) / (2 * d);
      return (p > 32768) ? 32768 : p;
   endfunction

   // Works out the expected result for one accepted iteration count.
   function void note_iteration(logic [31:0] iter);
      gait_result_type r;
      longint unsigned h, n, k, seg, frac, off, d, rel, s;
      bit bad;
      h = horizon;
      n = ticks;
      k = iter;
      r.seg = '0;
      r.frac = '0;
      r.contacts = '0;
      r.cfg_err = 1'b0;
      for (int l = 0; l < LEG_COUNT; l++) begin
         r.stance[l] = '0;
         r.swing[l] = '0;
      end
      bad = (h == 0) || (h > 16) || (n == 0);
      for (int l = 0; l < LEG_COUNT; l++) begin
         if (offsets[4*l +: 4] >= h || lengths[5*l +: 5] > h) bad = 1;
      end
      if (bad) begin
         r.cfg_err = 1'b1;
         pending_results.push_back(r);
         return;
      end
      seg = (k / n) % h;
      frac = ((k % n) * 65536) / n;
      r.seg = SEG_WIDTH'(seg);
      r.frac = FRAC_WIDTH'(frac);
      for (int l = 0; l < LEG_COUNT; l++) begin
         off = offsets[4*l +: 4];
         d = lengths[5*l +: 5];
         rel = (seg + h - off) % h;
         if (d == 0) r.stance[l] = PHASE_ONE;
         else if (rel < d) r.stance[l] = PHASE_WIDTH'(clip_phase(rel, frac, d));
         if (h != d && rel >= d) r.swing[l] = PHASE_WIDTH'(clip_phase(rel - d, frac, h - d));
         for (int st = 0; st < h; st++) begin
            s = (seg + st) % h;
            if (((s + h - off) % h) < d) r.contacts[st*4 + l] = 1'b1;
         end
      end
      pending_results.push_back(r);
   endfunction

   function void report(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("MISMATCH item %0d %s: got %0h expected %0h", checked, what, got, want);
   endfunction

   // Compares one result item with the oldest expectation.
   function void check_result(gait_result_type got);
      gait_result_type e;
      if (pending_results.size() == 0) begin
         report("result item arrived with nothing expected", 1, 0);
         return;
      end
      e = pending_results.pop_front();
      if (got.seg !== e.seg) report("segment_index", got.seg, e.seg);
      if (got.frac !== e.frac) report("segment_fraction", got.frac, e.frac);
      for (int l = 0; l < LEG_COUNT; l++) begin
         if (got.stance[l] !== e.stance[l])
            report($sformatf("stance_phase_leg%0d", l), got.stance[l], e.stance[l]);
         if (got.swing[l] !== e.swing[l])
            report($sformatf("swing_phase_leg%0d", l), got.swing[l], e.swing[l]);
      end
      if (got.contacts !== e.contacts) report("contact_bits", got.contacts, e.contacts);
      if (got.cfg_err !== e.cfg_err) report("config_error", got.cfg_err, e.cfg_err);
      if (e.cfg_err) error_results++;
      checked++;
   endfunction
endclass

module tb_top;
   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [31:0] req_control_iteration = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [SEG_WIDTH-1:0] rsp_segment_index;
   logic [FRAC_WIDTH-1:0] rsp_segment_fraction;
   logic [PHASE_WIDTH-1:0] rsp_stance_phase_leg0, rsp_stance_phase_leg1;
   logic [PHASE_WIDTH-1:0] rsp_stance_phase_leg2, rsp_stance_phase_leg3;
   logic [PHASE_WIDTH-1:0] rsp_swing_phase_leg0, rsp_swing_phase_leg1;
   logic [PHASE_WIDTH-1:0] rsp_swing_phase_leg2, rsp_swing_phase_leg3;
   logic [CONTACT_WIDTH-1:0] rsp_contact_bits;
   logic rsp_config_error;

   gait_scoreboard gait_sb = new();
   bit idle_enable = 1;
   bit hold_rsp = 0;
   int items_sent = 0;

   always #5 clock = ~clock;

   gait_phase_scheduler i_dut (.*);

   // Result side: random stall bursts, long hold-off on request, check on accept.
   always @(posedge clock) begin
      gait_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.seg = rsp_segment_index;
         got.frac = rsp_segment_fraction;
         got.stance[0] = rsp_stance_phase_leg0;
         got.stance[1] = rsp_stance_phase_leg1;
         got.stance[2] = rsp_stance_phase_leg2;
         got.stance[3] = rsp_stance_phase_leg3;
         got.swing[0] = rsp_swing_phase_leg0;
         got.swing[1] = rsp_swing_phase_leg1;
         got.swing[2] = rsp_swing_phase_leg2;
         got.swing[3] = rsp_swing_phase_leg3;
         got.contacts = rsp_contact_bits;
         got.cfg_err = rsp_config_error;
         gait_sb.check_result(got);
      end
   end

   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_stall <= 1;
         else if (idle_enable && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 0;
         end else rsp_stall <= 0;
      end
   end

   // Offers one iteration count and waits until it is accepted. Valid stays
   // high afterwards so that the next item can follow without a gap.
   task automatic send_iteration(logic [31:0] iter);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1;
      req_control_iteration <= iter;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gait_sb.note_iteration(iter);
      items_sent++;
      @(negedge clock);
   endtask

   // Stops offering items and waits until every expected result has come.
   task automatic drain_results();
      req_valid <= 0;
      while (gait_sb.pending_results.size() != 0) @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 0;
      gait_sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   // Random but valid gait: offsets below horizon, lengths up to horizon.
   task automatic random_gait(int h, int n);
      logic [15:0] offs;
      logic [19:0] lens;
      for (int l = 0; l < LEG_COUNT; l++) begin
         offs[4*l +: 4] = 4'($urandom_range(0, h - 1));
         lens[5*l +: 5] = 5'($urandom_range(0, h));
      end
      write_csr(CSR_HORIZON, CSR_DATA_WIDTH'(h));
      write_csr(CSR_TICKS, CSR_DATA_WIDTH'(n));
      write_csr(CSR_OFFSETS, CSR_DATA_WIDTH'(offs));
      write_csr(CSR_LENGTHS, lens);
   endtask

   function automatic logic [31:0] random_iteration();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 200);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 100);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      #2_000_000;
      $display("gait_phase_scheduler regression: fail");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: reset configuration, extreme iteration counts.
      send_iteration(32'h0);
      send_iteration(32'hFFFF_FFFF);
      send_iteration(32'd29);
      send_iteration(32'd30);
      send_iteration(32'h5555_5555);
      send_iteration(32'hAAAA_AAAA);
      drain_results();

      // Zero stance on one leg, full stance on another, horizon at maximum.
      write_csr(CSR_HORIZON, 16);
      write_csr(CSR_TICKS, 1024);
      write_csr(CSR_OFFSETS, 16'hF0A5);
      write_csr(CSR_LENGTHS, {5'd16, 5'd3, 5'd16, 5'd0});
      for (int i = 0; i < 6; i++) send_iteration(32'(i * 3000 + 511));
      send_iteration(32'hFFFF_FFFF);
      drain_results();

      // Single segment horizon and one tick per segment.
      write_csr(CSR_HORIZON, 1);
      write_csr(CSR_TICKS, 1);
      write_csr(CSR_OFFSETS, 0);
      write_csr(CSR_LENGTHS, {5'd1, 5'd0, 5'd1, 5'd0});
      send_iteration(32'd7);
      send_iteration(32'hFFFF_FFFF);
      drain_results();

      // Invalid settings: zero horizon, over-large horizon, zero ticks, bad fields.
      write_csr(CSR_HORIZON, 0);
      send_iteration(32'd5);
      drain_results();
      write_csr(CSR_HORIZON, 31);
      send_iteration(32'd5);
      drain_results();
      write_csr(CSR_HORIZON, 4);
      write_csr(CSR_TICKS, 0);
      send_iteration(32'd5);
      drain_results();
      write_csr(CSR_TICKS, 2047);
      write_csr(CSR_OFFSETS, 16'h0004);
      write_csr(CSR_LENGTHS, 0);
      send_iteration(32'd5000);
      drain_results();
      write_csr(CSR_OFFSETS, 0);
      write_csr(CSR_LENGTHS, 20'hFFFFF);
      send_iteration(32'd5000);
      send_iteration(32'd4095);
      drain_results();

      // Random phases, each with a fresh valid gait; some invalid ones mixed in.
      for (int ph = 0; ph < 30; ph++) begin
         if (ph == 29) idle_enable = 0;
         if (ph % 7 == 6) begin
            write_csr(CSR_HORIZON, CSR_DATA_WIDTH'($urandom_range(0, 31)));
            write_csr(CSR_TICKS, CSR_DATA_WIDTH'($urandom_range(0, 2047)));
            write_csr(CSR_OFFSETS, CSR_DATA_WIDTH'($urandom));
            write_csr(CSR_LENGTHS, CSR_DATA_WIDTH'($urandom));
         end else begin
            random_gait($urandom_range(1, 16), (ph % 3 == 0) ?
                        $urandom_range(1, 8) : $urandom_range(1, 2047));
         end
         if (ph == 10) begin
            // Long receiver hold-off so the pipeline fills and stalls the sender.
            hold_rsp = 1;
            fork
               begin
                  repeat (60) @(negedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         for (int i = 0; i < 29; i++) send_iteration(random_iteration());
         drain_results();
      end

      $display("Covered %0d items (%0d with config errors) over the reset, directed",
               gait_sb.checked, gait_sb.error_results);
      $display("and 30 random register settings, with stall bursts and one long hold-off.");
      if (gait_sb.mismatches == 0 && gait_sb.pending_results.size() == 0)
         $display("gait_phase_scheduler regression: pass");
      else
         $display("gait_phase_scheduler regression: fail");
      $finish;
   end
endmodule
